// ----- hdl/tps_pkg.sv -----
package tps_pkg;

   // Capacity of the sorting chain, one cell per kept sample.
   localparam int MaxValues = 64;
   localparam int DataW     = 32;
   // The fill count must be able to hold MaxValues itself.
   localparam int CntW      = $clog2(MaxValues + 1);
   localparam int SetSizeW  = 7;
   localparam int RspW      = 3 * DataW + SetSizeW + 1;
   localparam int RspBytesW = ((RspW + 7) / 8) * 8;

   // Percentile points, as integer percentages of the index range.
   localparam int PctCount = 3;
   localparam int PctScale = 100;
   localparam int PctHi    = 95;
   localparam int RemW     = $clog2((MaxValues - 1) * PctHi + 1);
   localparam logic [RemW-1:0] PctTab [PctCount] = '{
      RemW'(5), RemW'(50), RemW'(PctHi)
   };

   // Controls broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic             insert;
      logic             shift;
      logic [DataW-1:0] value;
   } tps_ctl_type;

   typedef enum logic [1:0] {
      ST_FILL = 2'b01,
      ST_WALK = 2'b10
   } tps_state_type;

endpackage

// ----- hdl/tps_cell.sv -----
module tps_cell
   import tps_pkg::*;
(
   input  logic             clock,
   input  tps_ctl_type      ctl,
   input  logic             occupied,
   input  logic             prev_bigger,
   input  logic [DataW-1:0] prev_data,
   input  logic [DataW-1:0] next_data,
   output logic [DataW-1:0] data,
   output logic             bigger
);

   logic [DataW-1:0] data_ff;
   logic [DataW-1:0] data_in;

   // An empty cell acts as an entry larger than any sample, so the new value
   // lands in the first empty cell when nothing stored exceeds it.
   assign bigger = !occupied || (data_ff > ctl.value);
   assign data   = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = next_data;
      end else if (ctl.insert && bigger) begin
         // Either take the new sample or make room by taking the left neighbor.
         data_in = prev_bigger ? prev_data : ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ----- hdl/three_percentile_select.sv -----
// Percentile selector for a set of unsigned 32-bit throughput samples.
// Samples arrive as transactions on the req_ channel, one sample per
// transaction in req_tdata, with req_tlast high on the final sample of a set.
// Each accepted sample is insertion-sorted into a chain of MaxValues cells in
// the same cycle, so a set streams in at one sample per cycle. Samples that
// arrive once the chain is full are dropped and flagged as overflow.
// After the last sample the chain shifts its contents toward the first cell,
// one entry per cycle, and three running remainders pick out the entries at
// sorted indices floor((n-1)*p/100) for p = 5, 50 and 95. The walk goes on until
// the entry at sorted index floor((n-1)*95/100) is reached, and then loads the
// result into the output register, which raises rsp_tvalid. req_tready is low
// during the walk; the next set may start streaming while a finished result
// still waits on the rsp_ channel. If the receiver stalls, the walk finishes
// and holds its picks until the output register frees up. A synchronous reset
// empties the set, clears the overflow flag and drops any pending result; the
// sample storage itself is not cleared, since only entries written within the
// current set are read.
module three_percentile_select
   import tps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [31:0] value
   input  logic [DataW-1:0]     req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [31:0] fifth_pct, [63:32] median_value, [95:64] ninety_fifth_pct,
   // [102:96] set_size, [103] overflow
   output logic [RspBytesW-1:0] rsp_tdata
);

   tps_state_type state_ff, state_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            dropped_ff, dropped_in;

   // Working registers of the percentile walk.
   logic [RemW-1:0]     rem_ff [PctCount];
   logic [RemW-1:0]     rem_in [PctCount];
   logic [PctCount-1:0] taken_ff, taken_in;
   logic [DataW-1:0]    pick_ff [PctCount];
   logic [DataW-1:0]    pick_in [PctCount];
   logic [SetSizeW-1:0] size_w_ff, size_w_in;
   logic                ovf_w_ff, ovf_w_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]      rsp_data_ff, rsp_data_in;

   tps_ctl_type          ctl;
   logic [DataW-1:0]     cell_data [MaxValues];
   logic [MaxValues-1:0] cell_bigger;
   logic [MaxValues-1:0] cell_occupied;

   logic            req_acc;
   logic            room;
   logic [CntW-1:0] n_next;
   logic [RemW-1:0] nm1;
   logic            out_free;

   assign req_tready = (state_ff == ST_FILL);
   assign req_acc    = req_tvalid && req_tready;
   assign room       = (fill_ff != CntW'(MaxValues));
   assign n_next     = room ? (fill_ff + CntW'(1)) : fill_ff;
   assign nm1        = RemW'(n_next - CntW'(1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ctl.insert = req_acc && room;
   assign ctl.shift  = (state_ff == ST_WALK);
   assign ctl.value  = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspBytesW'(rsp_data_ff);

   // The sorting chain: cell 0 holds the smallest sample.
   for (genvar gi = 0; gi < MaxValues; gi++) begin : g_cell
      assign cell_occupied[gi] = (fill_ff > CntW'(gi));
      if (gi == 0) begin : g_first
         tps_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (cell_occupied[gi]),
            .prev_bigger (1'b0),
            .prev_data   ({DataW{1'b0}}),
            .next_data   (cell_data[gi+1]),
            .data        (cell_data[gi]),
            .bigger      (cell_bigger[gi])
         );
      end else if (gi == MaxValues - 1) begin : g_last
         tps_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (cell_occupied[gi]),
            .prev_bigger (cell_bigger[gi-1]),
            .prev_data   (cell_data[gi-1]),
            .next_data   (cell_data[gi]),
            .data        (cell_data[gi]),
            .bigger      (cell_bigger[gi])
         );
      end else begin : g_mid
         tps_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (cell_occupied[gi]),
            .prev_bigger (cell_bigger[gi-1]),
            .prev_data   (cell_data[gi-1]),
            .next_data   (cell_data[gi+1]),
            .data        (cell_data[gi]),
            .bigger      (cell_bigger[gi])
         );
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      rem_in       = rem_ff;
      taken_in     = taken_ff;
      pick_in      = pick_ff;
      size_w_in    = size_w_ff;
      ovf_w_in     = ovf_w_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_FILL: begin
            if (req_acc) begin
               if (room) begin
                  fill_in = fill_ff + CntW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  // Close the set: latch its size and overflow, then start
                  // each remainder at (n-1)*p so that it drops below the
                  // scale exactly at the wanted sorted index.
                  size_w_in  = SetSizeW'(n_next);
                  ovf_w_in   = dropped_ff || !room;
                  fill_in    = '0;
                  dropped_in = 1'b0;
                  taken_in   = '0;
                  for (int j = 0; j < PctCount; j++) begin
                     rem_in[j] = RemW'(nm1 * PctTab[j]);
                  end
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // Cell 0 shows the next sorted entry in every cycle of the walk.
            for (int j = 0; j < PctCount; j++) begin
               if (!taken_ff[j]) begin
                  if (rem_ff[j] < RemW'(PctScale)) begin
                     pick_in[j]  = cell_data[0];
                     taken_in[j] = 1'b1;
                  end else begin
                     rem_in[j] = rem_ff[j] - RemW'(PctScale);
                  end
               end
            end
            if ((&taken_in) && out_free) begin
               rsp_data_in  = {ovf_w_ff, size_w_ff, pick_in[2], pick_in[1], pick_in[0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      pick_ff     <= pick_in;
      size_w_ff   <= size_w_in;
      ovf_w_ff    <= ovf_w_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hdl/tps_checker.sv -----
module tps_checker
   import tps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RspBytesW-1:0] rsp_tdata
);

   logic [DataW-1:0]    fifth_v;
   logic [DataW-1:0]    median_v;
   logic [DataW-1:0]    ninety_v;
   logic [SetSizeW-1:0] size_v;

   assign fifth_v  = rsp_tdata[DataW-1:0];
   assign median_v = rsp_tdata[2*DataW-1:DataW];
   assign ninety_v = rsp_tdata[3*DataW-1:2*DataW];
   assign size_v   = rsp_tdata[3*DataW+SetSizeW-1:3*DataW];

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction withdrawn while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // The three picks come from one sorted set, so they are ordered.
   a_pct_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fifth_v <= median_v) && (median_v <= ninety_v))
      else $error("percentiles out of order");

   // Every result describes a set with at least one kept sample.
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (size_v != '0))
      else $error("result with empty set size");

   // Reset discards any pending result.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind three_percentile_select tps_checker u_tps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_three_percentile_select.sv -----
// Self-checking bench for the percentile selector. Samples are streamed in as
// sets, and a scoreboard keeps its own sorted copy of each set so that it can
// predict the fifth, median and ninety-fifth percentile picks, the set size and
// the overflow flag of every result transaction.
module tb_three_percentile_select;
   import tps_pkg::*;

   // Percent points of the three picks, and the divisor that goes with them.
   localparam int LowPct     = 5;
   localparam int MidPct     = 50;
   localparam int HighPct    = 95;
   localparam int PctDiv     = 100;
   // Rough count of random samples to stream after the directed sets.
   localparam int RandomItems = 700;
   // Final wait, long enough to cover any result still in flight at the end.
   localparam int DrainCycles = 4 * MaxValues;
   // Long receiver stall used to back the chain up into its input.
   localparam int HoldCycles  = 400;
   // Generous ceiling on the whole run, measured in clock cycles.
   localparam int CycleLimit  = 300000;
   localparam int IdlePct     = 29;
   localparam int ReportLimit = 10;

   // How the samples of one set are drawn.
   typedef enum int {
      SPREAD_FULL,   // anywhere in the 32-bit range
      SPREAD_NARROW, // a handful of small values, so duplicates are common
      SPREAD_EDGE    // range ends and single-bit patterns
   } spread_type;

   // One result transaction, laid out as rsp_tdata carries it: the fifth
   // percentile in the lowest bits, the overflow flag in the top bit.
   typedef struct packed {
      logic                overflow;
      logic [SetSizeW-1:0] set_size;
      logic [DataW-1:0]    ninety_fifth_pct;
      logic [DataW-1:0]    median_value;
      logic [DataW-1:0]    fifth_pct;
   } pct_result_type;

   // The scoreboard holds the samples of the current set in ascending order,
   // turns each completed set into an expected result, and compares result
   // transactions with those expectations in arrival order.
   class percentile_scoreboard;
      logic [DataW-1:0] ranked_samples[$];
      logic             dropped;
      pct_result_type   pending_picks[$];
      int               failures;

      function new();
         dropped  = 1'b0;
         failures = 0;
      endfunction

      function void report(string what, logic [DataW-1:0] want, logic [DataW-1:0] got);
         failures++;
         if (failures <= ReportLimit) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
         end
      endfunction

      // Called for every sample accepted on the request channel.
      function void take_sample(logic [DataW-1:0] value, logic last);
         int             pos;
         int             n;
         pct_result_type want;
         if (ranked_samples.size() < MaxValues) begin
            // A new sample goes after every stored entry equal to it.
            pos = 0;
            while (pos < ranked_samples.size() && ranked_samples[pos] <= value) begin
               pos++;
            end
            ranked_samples.insert(pos, value);
         end else begin
            dropped = 1'b1;
         end
         if (last) begin
            n = ranked_samples.size();
            want.fifth_pct        = ranked_samples[((n - 1) * LowPct) / PctDiv];
            want.median_value     = ranked_samples[((n - 1) * MidPct) / PctDiv];
            want.ninety_fifth_pct = ranked_samples[((n - 1) * HighPct) / PctDiv];
            want.set_size         = SetSizeW'(n);
            want.overflow         = dropped;
            pending_picks.push_back(want);
            ranked_samples.delete();
            dropped = 1'b0;
         end
      endfunction

      // Called for every result transaction seen on the response channel.
      function void check_pick(logic [RspBytesW-1:0] data);
         pct_result_type got;
         pct_result_type want;
         got = data;
         if (pending_picks.size() == 0) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("unexpected result %h with no set pending", data);
            end
            return;
         end
         want = pending_picks.pop_front();
         if (got.fifth_pct !== want.fifth_pct)
            report("fifth_pct", want.fifth_pct, got.fifth_pct);
         if (got.median_value !== want.median_value)
            report("median_value", want.median_value, got.median_value);
         if (got.ninety_fifth_pct !== want.ninety_fifth_pct)
            report("ninety_fifth_pct", want.ninety_fifth_pct, got.ninety_fifth_pct);
         if (got.set_size !== want.set_size)
            report("set_size", DataW'(want.set_size), DataW'(got.set_size));
         if (got.overflow !== want.overflow)
            report("overflow", DataW'(want.overflow), DataW'(got.overflow));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DataW-1:0]     req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspBytesW-1:0] rsp_tdata;

   percentile_scoreboard board = new();

   // When set, neither side inserts idle cycles.
   bit steady = 1'b0;
   // Written by the stimulus to ask the receiver for a long stall.
   int hold_request = 0;
   int cycles = 0;

   three_percentile_select uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offers one sample, with random idle cycles ahead of it, and waits until
   // the block takes the transaction. All signals change only at rising edges,
   // and the handshake is judged on the values that stood before the edge.
   task automatic send_sample(input logic [DataW-1:0] value, input logic last);
      while (!steady && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.take_sample(value, last);
   endtask

   function automatic logic [DataW-1:0] draw_value(spread_type spread);
      logic [DataW-1:0] v;
      case (spread)
         SPREAD_NARROW: begin
            v = DataW'($urandom_range(7));
         end
         SPREAD_EDGE: begin
            case ($urandom_range(3))
               0:       v = '0;
               1:       v = '1;
               2:       v = DataW'(1) << $urandom_range(DataW - 1);
               default: v = ~(DataW'(1) << $urandom_range(DataW - 1));
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   // Streams one whole set of the given length; the final sample carries last.
   // Lengths beyond MaxValues overflow the chain, and their last sample is
   // among the dropped ones.
   task automatic send_set(input int len, input spread_type spread);
      for (int i = 0; i < len; i++) begin
         send_sample(draw_value(spread), i == len - 1);
      end
   endtask

   // Receiver: checks every result transaction and stalls at random. A long
   // stall asked for by the stimulus is counted down here, cycle by cycle.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_pick(rsp_tdata);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IdlePct);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int         sent;
      int         set_index;
      int         len;
      int         pick;
      spread_type spread;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed sets. A single sample at each end of the range, where all
      // three picks equal that sample.
      send_sample('0, 1'b1);
      send_sample('1, 1'b1);
      // The two range ends in falling order.
      send_sample('1, 1'b0);
      send_sample('0, 1'b1);
      // Equal samples only.
      send_sample(DataW'(7), 1'b0);
      send_sample(DataW'(7), 1'b0);
      send_sample(DataW'(7), 1'b1);
      // Strictly falling order, so every sample lands at the front.
      send_sample(DataW'(50), 1'b0);
      send_sample(DataW'(40), 1'b0);
      send_sample(DataW'(30), 1'b0);
      send_sample(DataW'(20), 1'b0);
      send_sample(DataW'(10), 1'b1);
      // Alternating bit patterns mixed with duplicates and range ends.
      send_sample(32'hAAAA_AAAA, 1'b0);
      send_sample(32'h5555_5555, 1'b0);
      send_sample(32'hAAAA_AAAA, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h5555_5555, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFE, 1'b1);

      // Random sets. Most are short so the walk stays quick; some fill the
      // chain exactly and some run past it to set the overflow flag.
      sent      = 0;
      set_index = 0;
      while (sent < RandomItems) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = $urandom_range(1, 12);
         end else if (pick < 75) begin
            len = $urandom_range(13, 40);
         end else if (pick < 85) begin
            len = $urandom_range(MaxValues - 2, MaxValues);
         end else begin
            len = $urandom_range(MaxValues + 1, MaxValues + 8);
         end
         case ($urandom_range(5))
            0, 1, 2: spread = SPREAD_FULL;
            3:       spread = SPREAD_NARROW;
            default: spread = SPREAD_EDGE;
         endcase
         // A stretch of sets with both sides running flat out.
         steady = (set_index >= 12 && set_index < 18);
         // Back pressure: the receiver stops for a long time while samples
         // keep coming, so a finished result blocks the walk and the block
         // has to stall its input.
         if (set_index == 6) begin
            hold_request = HoldCycles;
         end
         send_set(len, spread);
         sent += len;
         set_index++;
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (board.pending_picks.size() != 0) begin
         @(posedge clock);
      end
      // Let any stray result show up before the verdict.
      repeat (DrainCycles) @(posedge clock);

      if (board.failures == 0 && board.pending_picks.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/tps_pkg.sv
hdl/tps_cell.sv
hdl/three_percentile_select.sv
hdl/tps_checker.sv
bench/tb_three_percentile_select.sv
